@@ rtl/ttlmb_pkg.sv @@
// Shared types and constants of the time-to-live message buffer.
// Holds operation codes, controller states and the controller/datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps

package ttlmb_pkg;

   // Fixed field widths of the stream ports
   localparam int PAYLOAD_BITS = 64;
   localparam int AGE_BITS     = 16;
   localparam int COUNT_BITS   = 5;
   localparam int REQ_TDATA_BITS = 64;
   localparam int RSP_TDATA_BITS = 88;
   localparam int RSP_TUSER_BITS = 2;

   // Defaults for the top-level parameters
   localparam int DEPTH_DEFAULT         = 16;
   localparam int PAYLOAD_WIDTH_DEFAULT = 64;

   // Time-to-live after reset
   localparam logic [AGE_BITS-1:0] TTL_RESET = 16'd10;

   // Operation codes carried in req_tuser
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_ADD   = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_CLEAR,
      ST_TICK,
      ST_READ,
      ST_PUSH,
      ST_STATUS,
      ST_DROP,
      ST_EMPTY
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic latch;         // transaction accepted: capture payload, rewind walk
      logic add_write;     // append the captured payload if not full
      logic clear;         // empty the buffer
      logic tick_step;     // one step of the aging and compaction walk
      logic tick_commit;   // take the compacted count
      logic rd_first;      // read the entry under the walk index
      logic rd_next;       // read the following entry and advance the index
      logic out_status;    // load a status result
      logic status_drop;   // status result flags a refused add
      logic status_empty;  // status result flags an empty read
      logic out_entry;     // load an entry result from the read data
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic full;
      logic count_zero;
      logic tick_done;
      logic entry_last;
      logic out_free;
   } dp_stat_type;

endpackage

@@ rtl/ttlmb_ctrl.sv @@
// Controller of the time-to-live message buffer: sequences each operation.
// Depends on ttlmb_pkg; drives the datapath through dp_cmd_type.
`timescale 1ns / 1ps

module ttlmb_ctrl
   import ttlmb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_func,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;
   func_type  func;

   assign func = func_type'(req_func);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (func)
                  FUNC_TICK:  state_in = ST_TICK;
                  FUNC_ADD:   state_in = ST_ADD;
                  FUNC_READ:  state_in = ST_READ;
                  FUNC_CLEAR: state_in = ST_CLEAR;
               endcase
            end
         end
         ST_ADD:   state_in = stat.full ? ST_DROP : ST_STATUS;
         ST_CLEAR: state_in = ST_STATUS;
         ST_TICK: begin
            if (stat.tick_done) state_in = ST_STATUS;
         end
         ST_READ:  state_in = stat.count_zero ? ST_EMPTY : ST_PUSH;
         ST_PUSH: begin
            if (stat.out_free && stat.entry_last) state_in = ST_IDLE;
         end
         ST_STATUS, ST_DROP, ST_EMPTY: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.latch  = req_tvalid;
         end
         ST_ADD:   cmd.add_write = 1'b1;
         ST_CLEAR: cmd.clear = 1'b1;
         ST_TICK: begin
            cmd.tick_step   = 1'b1;
            cmd.tick_commit = stat.tick_done;
         end
         ST_READ:  cmd.rd_first = !stat.count_zero;
         ST_PUSH: begin
            cmd.out_entry = stat.out_free;
            cmd.rd_next   = stat.out_free && !stat.entry_last;
         end
         ST_STATUS: cmd.out_status = stat.out_free;
         ST_DROP: begin
            cmd.out_status  = stat.out_free;
            cmd.status_drop = 1'b1;
         end
         ST_EMPTY: begin
            cmd.out_status   = stat.out_free;
            cmd.status_empty = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

endmodule

@@ rtl/ttlmb_datapath.sv @@
// Datapath of the time-to-live message buffer: entry memory, counters,
// time-to-live register and result register. Depends on ttlmb_pkg.
`timescale 1ns / 1ps

module ttlmb_datapath
   import ttlmb_pkg::*;
#(
   parameter int DEPTH         = DEPTH_DEFAULT,
   parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_stat_type             stat,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   input  logic                    csr_valid,
   input  logic [AGE_BITS-1:0]     csr_data,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [PAYLOAD_BITS-1:0] rsp_payload,
   output logic [AGE_BITS-1:0]     rsp_age,
   output logic                    rsp_last,
   output logic                    rsp_empty,
   output logic                    rsp_dropped,
   output logic [COUNT_BITS-1:0]   rsp_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Entry memory
   logic [PAYLOAD_WIDTH-1:0] pay_mem [DEPTH];
   logic [AGE_BITS-1:0]      age_mem [DEPTH];

   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            keep_ff, keep_in;
   logic                     rd_pend_ff;
   logic [AGE_BITS-1:0]      ttl_ff;
   logic [PAYLOAD_WIDTH-1:0] pay_ff;
   logic [PAYLOAD_WIDTH-1:0] rd_pay_ff;
   logic [AGE_BITS-1:0]      rd_age_ff;

   logic                     out_valid_ff, out_valid_in;
   logic [PAYLOAD_BITS-1:0]  out_pay_ff;
   logic [AGE_BITS-1:0]      out_age_ff;
   logic                     out_last_ff;
   logic                     out_empty_ff;
   logic                     out_drop_ff;
   logic [COUNT_BITS-1:0]    out_count_ff;

   logic [CW-1:0]            idx_inc;
   logic                     full;
   logic                     walk_more;
   logic                     tick_issue;
   logic                     tick_keep;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [PAYLOAD_WIDTH-1:0] wr_pay;
   logic [AGE_BITS-1:0]      wr_age;
   logic                     out_free;
   logic                     out_load;

   // Walk and address decode
   assign idx_inc    = idx_ff + CW'(1);
   assign full       = (count_ff == CW'(DEPTH));
   assign walk_more  = (idx_ff < count_ff);
   assign tick_issue = cmd.tick_step && walk_more;
   assign tick_keep  = rd_pend_ff && (rd_age_ff < ttl_ff);
   assign rd_en      = tick_issue || cmd.rd_first || cmd.rd_next;
   assign rd_addr    = cmd.rd_next ? idx_inc[AW-1:0] : idx_ff[AW-1:0];
   assign wr_en      = (cmd.add_write && !full) || tick_keep;
   assign wr_addr    = cmd.add_write ? count_ff[AW-1:0] : keep_ff[AW-1:0];
   assign wr_pay     = cmd.add_write ? pay_ff : rd_pay_ff;
   assign wr_age     = cmd.add_write ? '0 : rd_age_ff + AGE_BITS'(1);

   // Memory write and registered read; compaction writes only below the read index
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pay_mem[wr_addr] <= wr_pay;
         age_mem[wr_addr] <= wr_age;
      end
      if (rd_en) begin
         rd_pay_ff <= pay_mem[rd_addr];
         rd_age_ff <= age_mem[rd_addr];
      end
   end

   // Counter next values
   always_comb begin
      count_in = count_ff;
      priority if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.add_write && !full) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.tick_commit) begin
         count_in = keep_ff;
      end

      idx_in = idx_ff;
      priority if (cmd.latch) begin
         idx_in = '0;
      end else if (tick_issue || cmd.rd_next) begin
         idx_in = idx_inc;
      end

      keep_in = keep_ff;
      priority if (cmd.latch) begin
         keep_in = '0;
      end else if (tick_keep) begin
         keep_in = keep_ff + CW'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         keep_ff    <= '0;
         rd_pend_ff <= 1'b0;
         ttl_ff     <= TTL_RESET;
      end else begin
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         keep_ff    <= keep_in;
         rd_pend_ff <= tick_issue;
         if (csr_valid) ttl_ff <= csr_data;
      end
   end

   // Capture the payload of an accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.latch) pay_ff <= req_payload[PAYLOAD_WIDTH-1:0];
   end

   // Result register: load when empty or being drained
   assign out_free     = !out_valid_ff || rsp_tready;
   assign out_load     = cmd.out_status || cmd.out_entry;
   assign out_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_entry) begin
         out_pay_ff   <= PAYLOAD_BITS'(rd_pay_ff);
         out_age_ff   <= rd_age_ff;
         out_last_ff  <= (idx_inc == count_ff);
         out_empty_ff <= 1'b0;
         out_drop_ff  <= 1'b0;
         out_count_ff <= COUNT_BITS'(count_ff);
      end else if (cmd.out_status) begin
         out_pay_ff   <= '0;
         out_age_ff   <= '0;
         out_last_ff  <= 1'b1;
         out_empty_ff <= cmd.status_empty;
         out_drop_ff  <= cmd.status_drop;
         out_count_ff <= COUNT_BITS'(count_ff);
      end
   end

   // Status to controller
   assign stat.full       = full;
   assign stat.count_zero = (count_ff == '0);
   assign stat.tick_done  = !walk_more && !rd_pend_ff;
   assign stat.entry_last = (idx_inc == count_ff);
   assign stat.out_free   = out_free;

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_payload = out_pay_ff;
   assign rsp_age     = out_age_ff;
   assign rsp_last    = out_last_ff;
   assign rsp_empty   = out_empty_ff;
   assign rsp_dropped = out_drop_ff;
   assign rsp_count   = out_count_ff;

endmodule

@@ rtl/ttl_message_buffer.sv @@
// Top level of the time-to-live message buffer.
// Depends on ttlmb_pkg, ttlmb_ctrl and ttlmb_datapath.
`timescale 1ns / 1ps
//
// Usage:
//   req_* carries one operation per transaction: req_tuser selects tick, add,
//   read or clear, req_tdata the payload used by add. rsp_* returns results;
//   rsp_tlast marks the final result of an operation. csr_* writes the
//   time-to-live register; the user must write it only while the buffer is
//   idle, which the block itself does not enforce; csr_ready is always high.
// Sequence (from accept to the result valid, with a free result register):
//   add and clear pass through their own state and then a status state,
//   which loads the result register; tick walks the live_count entries
//   taken before the tick, by one memory read port with compaction writes
//   behind it, then loads its status; read fetches its first entry in the
//   read state, then loads one entry per cycle while the result register is
//   free. The next transaction is accepted in the cycle after the final
//   result is loaded into the result register, even while it still waits.
// Reset: the buffer is empty and the time-to-live register holds 10.
// Stall: while rsp_tready is low the result register holds; a read walk
//   pauses on its current entry and resumes when the result is taken.

module ttl_message_buffer
   import ttlmb_pkg::*;
#(
   parameter int DEPTH         = DEPTH_DEFAULT,
   parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,   // [63:0] payload
   input  logic [1:0]                req_tuser,   // [1:0] func
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,   // [63:0] entry_payload,
                                                  // [79:64] entry_age,
                                                  // [84:80] live_count, zero fill
   output logic                      rsp_tlast,   // is_last
   output logic [RSP_TUSER_BITS-1:0] rsp_tuser,   // [0] is_empty, [1] dropped
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [AGE_BITS-1:0]       csr_data     // time_to_live
);

   dp_cmd_type              cmd;
   dp_stat_type             stat;
   logic [PAYLOAD_BITS-1:0] rsp_payload;
   logic [AGE_BITS-1:0]     rsp_age;
   logic                    rsp_empty;
   logic                    rsp_dropped;
   logic [COUNT_BITS-1:0]   rsp_count;

   ttlmb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   ttlmb_datapath #(
      .DEPTH         (DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_tdata),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_payload (rsp_payload),
      .rsp_age     (rsp_age),
      .rsp_last    (rsp_tlast),
      .rsp_empty   (rsp_empty),
      .rsp_dropped (rsp_dropped),
      .rsp_count   (rsp_count)
   );

   // Pack the result transaction
   assign rsp_tdata = {
      {(RSP_TDATA_BITS - PAYLOAD_BITS - AGE_BITS - COUNT_BITS){1'b0}},
      rsp_count, rsp_age, rsp_payload
   };
   assign rsp_tuser = {rsp_dropped, rsp_empty};
   assign csr_ready = 1'b1;

   // One operation at a time
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("transaction accepted while an operation is in flight");

   // An empty read reports nothing live and no payload
   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_empty) |->
         (rsp_tlast && rsp_count == '0 && rsp_payload == '0 && rsp_age == '0))
      else $error("empty read result carries data");

   // A refused add happens only on a full buffer
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_dropped) |-> (rsp_tlast && rsp_count == COUNT_BITS'(DEPTH)))
      else $error("add refused while buffer not full");

   // Empty and dropped never mark the same result
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tuser))
      else $error("empty and dropped both set");

endmodule
